>>> rtl/fbpa_pkg.sv
// Shared types, constants and helper functions of the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

  // Field widths fixed by the transaction formats.
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 16;
  localparam int CNT_W  = 11;
  localparam int ST_W   = 3;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;

  // Free bitmap organisation: one memory row holds the flags of ROW_W blocks.
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;

  // Register reset values.
  localparam logic [ADDR_W-1:0] BASE_RESET = '0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd64;
  localparam int                CNT_RESET  = 1024;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_BLOCK_COUNT = 2'd2;

  // Request kinds.
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_START = 3'd3;
  localparam logic [ST_W-1:0] ST_FREED     = 3'd4;

  // Status of the iterative divider towards the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Position of the lowest set bit of a row; zero when the row is empty.
  function automatic logic [ROW_BW-1:0] lowest_set(input logic [ROW_W-1:0] row);
    logic [ROW_BW-1:0] pos;
    pos = '0;
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (row[j]) begin
        pos = ROW_BW'(j);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: sequencer, free bitmap and registers.
`default_nettype none

// Channel        Direction  Contents
// s_axis_*       in         tuser: func; tdata: release_address
// m_axis_*       out        tdata: status, block_address, free_count (low bit first)
// cfg_*          in         register write: index in cfg_addr, value in cfg_data
//
// An allocate scans the summary one 32-row chunk at a time, past every chunk that
// holds no free block; a release waits on the eleven steps of the divider that
// turns the offset into a block index.
// Reset starts a clearing pass over the bitmap memory, one row (32 blocks) a
// cycle; a block_count write starts the same pass.
// No request is taken during the pass. A stalled result waits in the output
// register; a new request is taken meanwhile and its result waits for it.

module fixed_block_pool_allocator_top #(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Request stream.
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [31:0]                 s_axis_tdata,  // [31:0] release_address
  input  wire logic [0:0]                  s_axis_tuser,  // [0] func
  // Result stream.
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [47:0]                      m_axis_tdata,  // [2:0] status,
                                                          // [34:3] block_address,
                                                          // [45:35] free_count
  // Configuration writes.
  input  wire logic                        cfg_we,
  input  wire logic [fbpa_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [fbpa_pkg::CFG_DW-1:0] cfg_data
);
  import fbpa_pkg::*;

  // Bitmap geometry derived from the block bound.
  localparam int NROWS  = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int NCHUNK = (NROWS + ROW_W - 1) / ROW_W;
  localparam int CH_AW  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int XW     = ROW_AW + ROW_BW;
  localparam int MB_W   = (XW > CNT_W) ? XW : CNT_W;
  localparam int PROD_W = SIZE_W + MB_W;
  localparam int CMP_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
  localparam logic [CNT_W-1:0] CNT_INIT =
    CNT_W'((CNT_RESET > MAX_BLOCKS) ? MAX_BLOCKS : CNT_RESET);

  // Sequencer states.
  localparam int STATE_W = 4;
  localparam logic [STATE_W-1:0] S_IDLE   = 4'd0;
  localparam logic [STATE_W-1:0] S_SWEEP  = 4'd1;
  localparam logic [STATE_W-1:0] S_A_SCAN = 4'd2;
  localparam logic [STATE_W-1:0] S_A_PICK = 4'd3;
  localparam logic [STATE_W-1:0] S_A_MUL  = 4'd4;
  localparam logic [STATE_W-1:0] S_A_ADD  = 4'd5;
  localparam logic [STATE_W-1:0] S_R_SUB  = 4'd6;
  localparam logic [STATE_W-1:0] S_R_EXT  = 4'd7;
  localparam logic [STATE_W-1:0] S_R_CHK  = 4'd8;
  localparam logic [STATE_W-1:0] S_R_DIV  = 4'd9;
  localparam logic [STATE_W-1:0] S_R_REM  = 4'd10;
  localparam logic [STATE_W-1:0] S_R_TEST = 4'd11;
  localparam logic [STATE_W-1:0] S_DONE   = 4'd12;

  // Configuration registers; the count is held already clamped to the bound.
  logic [ADDR_W-1:0] pool_base;
  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  cfg_count;

  // Control state.
  logic [STATE_W-1:0] state;
  logic [ROW_AW-1:0]  sweep_row;
  logic [CH_AW-1:0]   chunk;
  logic [CNT_W-1:0]   free_total;
  logic [NCHUNK*ROW_W-1:0] summary;

  // Working registers of the current request.
  logic              func;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] offset;
  logic [ST_W-1:0]   status;
  logic [ADDR_W-1:0] res_addr;
  logic [ROW_AW-1:0] row_reg;
  logic [ROW_BW-1:0] bit_reg;
  logic [XW-1:0]     idx_x;
  logic [PROD_W-1:0] prod;

  // Output register.
  logic [ST_W-1:0]   out_status;
  logic [ADDR_W-1:0] out_addr;
  logic [CNT_W-1:0]  out_free;

  // Bitmap memory and its ports.
  logic [ROW_W-1:0]  map_mem [NROWS];
  logic [ROW_W-1:0]  row_q;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_row;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_row;
  logic [ROW_W-1:0]  wr_data;

  // Combinational helpers.
  logic [ROW_W-1:0]  chunk_bits;
  logic [ROW_AW-1:0] scan_row;
  logic [ROW_BW-1:0] pick_bit;
  logic [ROW_W-1:0]  pick_row;
  logic [ROW_W-1:0]  sweep_pat;
  logic [XW-1:0]     sweep_base;
  logic [MB_W-1:0]   mul_b;
  logic [XW-1:0]     rel_idx;
  logic              accept;
  logic              out_load;

  // Divider interface.
  div_status_t       div_st;
  logic              div_start;
  logic [CNT_W-1:0]  div_q;
  logic              div_rem_zero;

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (offset),
    .divisor  (block_size),
    .st       (div_st),
    .quotient (div_q),
    .rem_zero (div_rem_zero)
  );

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_load      = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign div_start     = (state == S_R_CHK) &&
                         (CMP_W'(offset) < CMP_W'(prod));

  // A block count beyond the bound behaves as the bound.
  assign cfg_count = (32'(cfg_data[CNT_W-1:0]) > 32'(MAX_BLOCKS)) ?
                     CNT_W'(MAX_BLOCKS) : cfg_data[CNT_W-1:0];

  // Summary scan: one chunk of 32 row flags per cycle.
  assign chunk_bits = summary[chunk*ROW_W +: ROW_W];
  assign scan_row   = ROW_AW'({chunk, lowest_set(chunk_bits)});
  assign pick_bit   = lowest_set(row_q);
  assign pick_row   = row_q & ~(ROW_W'(1) << pick_bit);

  // Clearing pass pattern: a block is free exactly when its index is below the count.
  assign sweep_base = {sweep_row, ROW_BW'(0)};
  always_comb begin
    sweep_pat = '0;
    for (int j = 0; j < ROW_W; j++) begin
      sweep_pat[j] = ((MB_W + 1)'(sweep_base) + (MB_W + 1)'(j)) <
                     (MB_W + 1)'(count_eff);
    end
  end

  // The shared multiplier forms the block address and the pool extent.
  assign mul_b   = (state == S_A_MUL) ? MB_W'(idx_x) : MB_W'(count_eff);
  assign rel_idx = XW'(div_q);

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_row  = scan_row;
    wr_en   = 1'b0;
    wr_row  = row_reg;
    wr_data = pick_row;
    unique case (state)
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_row  = sweep_row;
        wr_data = sweep_pat;
      end
      S_A_SCAN: begin
        rd_en  = |chunk_bits;
        rd_row = scan_row;
      end
      S_A_PICK: begin
        wr_en   = 1'b1;
        wr_data = pick_row;
      end
      S_R_REM: begin
        rd_en  = div_rem_zero;
        rd_row = rel_idx[XW-1:ROW_BW];
      end
      S_R_TEST: begin
        wr_en   = !row_q[bit_reg];
        wr_data = row_q | (ROW_W'(1) << bit_reg);
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      row_q <= map_mem[rd_row];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= BASE_RESET;
      block_size <= SIZE_RESET;
      count_eff  <= CNT_INIT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_POOL_BASE:   pool_base  <= cfg_data;
        REG_BLOCK_SIZE:  block_size <= cfg_data[SIZE_W-1:0];
        REG_BLOCK_COUNT: count_eff  <= cfg_count;
        default:         pool_base  <= pool_base;
      endcase
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_row  <= '0;
      chunk      <= '0;
      free_total <= CNT_INIT;
      summary    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            chunk <= '0;
            state <= (s_axis_tuser[0] == FUNC_RELEASE) ? S_R_SUB : S_A_SCAN;
          end
        end
        S_SWEEP: begin
          summary[sweep_row] <= |sweep_pat;
          if (sweep_row == ROW_AW'(NROWS - 1)) begin
            state <= S_IDLE;
          end else begin
            sweep_row <= sweep_row + 1'b1;
          end
        end
        S_A_SCAN: begin
          if (|chunk_bits) begin
            state <= S_A_PICK;
          end else if (chunk == CH_AW'(NCHUNK - 1)) begin
            state <= S_DONE;
          end else begin
            chunk <= chunk + 1'b1;
          end
        end
        S_A_PICK: begin
          summary[row_reg] <= |pick_row;
          free_total       <= free_total - 1'b1;
          state            <= S_A_MUL;
        end
        S_A_MUL:  state <= S_A_ADD;
        S_A_ADD:  state <= S_DONE;
        S_R_SUB:  state <= (req_addr < pool_base) ? S_DONE : S_R_EXT;
        S_R_EXT:  state <= S_R_CHK;
        S_R_CHK:  state <= div_start ? S_R_DIV : S_DONE;
        S_R_DIV: begin
          if (div_st.done) begin
            state <= S_R_REM;
          end
        end
        S_R_REM:  state <= div_rem_zero ? S_R_TEST : S_DONE;
        S_R_TEST: begin
          if (!row_q[bit_reg]) begin
            summary[row_reg] <= 1'b1;
            free_total       <= free_total + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // A block count write frees every block and restarts the clearing pass.
      if (cfg_we && (cfg_addr == REG_BLOCK_COUNT)) begin
        free_total <= cfg_count;
        sweep_row  <= '0;
        state      <= S_SWEEP;
      end
    end
  end

  // Working registers of the request in flight.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          func     <= s_axis_tuser[0];
          req_addr <= s_axis_tdata;
          status   <= ST_OK;
          res_addr <= '0;
        end
      end
      S_A_SCAN: begin
        if (|chunk_bits) begin
          row_reg <= scan_row;
        end else if (chunk == CH_AW'(NCHUNK - 1)) begin
          status <= ST_EMPTY;
        end
      end
      S_A_PICK: idx_x    <= {row_reg, pick_bit};
      S_A_MUL:  prod     <= PROD_W'(block_size) * PROD_W'(mul_b);
      S_A_ADD:  res_addr <= pool_base + ADDR_W'(prod);
      S_R_SUB: begin
        offset <= req_addr - pool_base;
        if (req_addr < pool_base) begin
          status <= ST_OUTSIDE;
        end
      end
      S_R_EXT:  prod <= PROD_W'(block_size) * PROD_W'(mul_b);
      S_R_CHK: begin
        if (!div_start) begin
          status <= ST_OUTSIDE;
        end
      end
      S_R_REM: begin
        row_reg <= rel_idx[XW-1:ROW_BW];
        bit_reg <= rel_idx[ROW_BW-1:0];
        if (!div_rem_zero) begin
          status <= ST_NOT_START;
        end
      end
      S_R_TEST: begin
        if (row_q[bit_reg]) begin
          status <= ST_FREED;
        end
      end
      default: begin
        status <= status;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status;
      out_addr   <= res_addr;
      out_free   <= free_total;
    end
  end

  assign m_axis_tdata = {2'b00, out_free, out_addr, out_status};

  // The free total never exceeds the block count.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= count_eff)
    else $error("free total above block count");

  // An empty pool is reported only when nothing is free.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status == ST_EMPTY) |-> (out_free == '0))
    else $error("pool empty reported with free blocks");

  // A failed request never carries a block address.
  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_status != ST_OK) |-> (out_addr == '0))
    else $error("address on failed request");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_R_DIV))
    else $error("divider finished outside its wait state");

  // A request is taken only with the sequencer idle, so func is steady meanwhile.
  a_func_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) && ($past(state) != S_IDLE) |-> $stable(func))
    else $error("request kind changed mid-request");

endmodule

`default_nettype wire

>>> rtl/fbpa_div.sv
// Restoring shift-and-subtract divider, one quotient bit per cycle.
`default_nettype none

module fbpa_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  wire logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output fbpa_pkg::div_status_t            st,
  output logic [fbpa_pkg::CNT_W-1:0]       quotient,
  output logic                             rem_zero
);
  import fbpa_pkg::*;

  // The dividend is known to be below divisor * 2^CNT_W, so CNT_W steps suffice.
  localparam int STEP_W = $clog2(CNT_W);

  logic [ADDR_W-1:0] rem;
  logic [CNT_W-1:0]  quot;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [ADDR_W-1:0] trial;
  logic              fits;

  assign trial = ADDR_W'(divisor) << step;
  assign fits  = (rem >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(CNT_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      quot <= '0;
    end else if (busy && fits) begin
      rem        <= rem - trial;
      quot[step] <= 1'b1;
    end
  end

  assign st.busy  = busy;
  assign st.done  = done;
  assign quotient = quot;
  assign rem_zero = (rem == '0);

endmodule

`default_nettype wire

>>> tb/fbpa_checker.sv
// Checker for the block pool allocator: predicts every result and compares the result stream.
`timescale 1ns / 100ps

module fbpa_checker #(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,   // [31:0] release_address
  input  logic [0:0]                  s_axis_tuser,   // [0] func
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [47:0]                 m_axis_tdata,   // [2:0] status, [34:3] block_address,
                                                      // [45:35] free_count
  input  logic                        cfg_we,
  input  logic [fbpa_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [fbpa_pkg::CFG_DW-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import fbpa_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] block_address;
    logic [CNT_W-1:0]  free_count;
  } pool_result_t;

  logic [ADDR_W-1:0] pool_base_q;
  logic [SIZE_W-1:0] block_size_q;
  logic [CNT_W-1:0]  block_count_q;
  bit                free_map [MAX_BLOCKS];
  logic [CNT_W-1:0]  free_total;
  pool_result_t      expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int unsigned usable_blocks();
    return (block_count_q > MAX_BLOCKS) ? MAX_BLOCKS : block_count_q;
  endfunction

  task automatic refill_pool();
    int unsigned n;
    n = usable_blocks();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free_map[i] = (i < n);
    end
    free_total = CNT_W'(n);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 200) begin
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  // Works out the outcome of one request and updates the free state.
  task automatic serve_request(input logic func, input logic [ADDR_W-1:0] addr,
                               output pool_result_t res);
    int unsigned       n;
    int unsigned       idx;
    bit                found;
    longint unsigned   extent;
    logic [ADDR_W-1:0] offset;
    n     = usable_blocks();
    idx   = 0;
    found = 1'b0;
    res   = '0;
    if (func == FUNC_ALLOC) begin
      for (int i = 0; i < n && !found; i++) begin
        if (free_map[i]) begin
          found = 1'b1;
          idx   = i;
        end
      end
      if (found) begin
        free_map[idx]     = 1'b0;
        free_total        = free_total - 1'b1;
        res.block_address = pool_base_q + block_size_q * idx;
        res.status        = ST_OK;
      end else begin
        res.status = ST_EMPTY;
      end
    end else begin
      extent = 64'(block_size_q) * 64'(n);
      offset = addr - pool_base_q;
      if (addr < pool_base_q || 64'(offset) >= extent) begin
        res.status = ST_OUTSIDE;
      end else if (offset % block_size_q != 0) begin
        res.status = ST_NOT_START;
      end else begin
        idx = offset / block_size_q;
        if (idx >= MAX_BLOCKS || free_map[idx]) begin
          res.status = ST_FREED;
        end else begin
          free_map[idx] = 1'b1;
          free_total    = free_total + 1'b1;
          res.status    = ST_OK;
        end
      end
    end
    res.free_count = free_total;
  endtask

  always @(posedge clk) begin
    pool_result_t got;
    pool_result_t want;
    if (rst) begin
      pool_base_q   = BASE_RESET;
      block_size_q  = SIZE_RESET;
      block_count_q = CNT_W'(CNT_RESET);
      refill_pool();
      expected_results.delete();
    end else begin
      // The result leaving at this edge can only belong to an earlier request.
      if (m_axis_tvalid && m_axis_tready) begin
        got.status        = m_axis_tdata[2:0];
        got.block_address = m_axis_tdata[34:3];
        got.free_count    = m_axis_tdata[45:35];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status)
            report_mismatch("status", got.status, want.status);
          if (got.block_address != want.block_address)
            report_mismatch("block_address", got.block_address, want.block_address);
          if (got.free_count != want.free_count)
            report_mismatch("free_count", got.free_count, want.free_count);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        serve_request(s_axis_tuser[0], s_axis_tdata, want);
        expected_results.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_POOL_BASE:   pool_base_q = cfg_data[ADDR_W-1:0];
          REG_BLOCK_SIZE:  block_size_q = cfg_data[SIZE_W-1:0];
          REG_BLOCK_COUNT: begin
            block_count_q = cfg_data[CNT_W-1:0];
            refill_pool();
          end
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/tb_fixed_block_pool_allocator_top.sv
// Testbench top for the block pool allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator_top;
  import fbpa_pkg::*;

  localparam int MAX_BLOCKS = 1024;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;   // [31:0] release_address
  logic [0:0]        s_axis_tuser  = '0;   // [0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;         // [2:0] status, [34:3] block_address,
                                           // [45:35] free_count
  logic              cfg_we        = 1'b0;
  logic [CFG_AW-1:0] cfg_addr      = '0;
  logic [CFG_DW-1:0] cfg_data      = '0;

  int fail_count;
  int pending;

  // Idling percentages for the two sides, changed from phase to phase.
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 46;

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit stall_burst = 1'b0;

  // The stimulus keeps its own copy of the registers so that it can aim release
  // addresses at block starts, near misses and points outside the pool.
  logic [ADDR_W-1:0] cur_base  = BASE_RESET;
  logic [SIZE_W-1:0] cur_size  = SIZE_RESET;
  logic [CNT_W-1:0]  cur_count = CNT_W'(CNT_RESET);

  fixed_block_pool_allocator_top #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  fbpa_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random back-pressure, or a long hold-off when one is asked for. The
  // hold-off is counted here, so the sender carries on offering transactions
  // until the allocator fills up and refuses them.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_burst) begin
        stall_burst = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (299) begin
          @(posedge clk);
          m_axis_tready <= 1'b0;
        end
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request and returns at the edge at which the transaction is
  // accepted. The valid is left high, so back-to-back requests never see it
  // dropped and raised in the same time step.
  task automatic send_request(input logic func, input logic [31:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= addr;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops offering and waits until the checker holds no outstanding result.
  // The loop waits on the clock before its first look, so that the last accepted
  // request has already been counted.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Register writes only happen with the allocator idle. The pause after the
  // drain covers the latency of a release, the slowest request.
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [31:0] value);
    drain_results();
    repeat (30) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    case (idx)
      REG_POOL_BASE:   cur_base  = value[ADDR_W-1:0];
      REG_BLOCK_SIZE:  cur_size  = value[SIZE_W-1:0];
      REG_BLOCK_COUNT: cur_count = value[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Chooses a release address. Most aim at block starts, biased towards low
  // indices because allocation always hands out the lowest free block; the
  // rest are misaligned, just outside the pool, or entirely random.
  function automatic logic [31:0] pick_release_address();
    int unsigned       n;
    int unsigned       k;
    int unsigned       pick;
    logic [ADDR_W-1:0] start;
    n    = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
    k    = 0;
    pick = $urandom_range(0, 99);
    if (n > 0) begin
      if ($urandom_range(0, 9) < 7)
        k = $urandom_range(0, ((n < 48) ? n : 48) - 1);
      else
        k = $urandom_range(0, n - 1);
    end
    start = cur_base + cur_size * k;
    if (pick < 60)
      return start;
    else if (pick < 75)
      return start + $urandom_range(1, (cur_size > 1) ? cur_size - 1 : 1);
    else if (pick < 88) begin
      if ($urandom_range(0, 1) == 0)
        return cur_base - $urandom_range(1, 4096);
      else
        return cur_base + cur_size * n + $urandom_range(0, 4096);
    end
    return $urandom();
  endfunction

  // A run of random requests, half allocations and half releases. Optionally
  // the receiver is asked for a long hold-off a third of the way in, and the
  // sender pauses half way until every result has come back.
  task automatic run_random(input int n_items, input bit with_burst, input bit with_pause);
    for (int i = 0; i < n_items; i++) begin
      if (with_burst && i == n_items / 3)
        stall_burst = 1'b1;
      if (with_pause && i == n_items / 2)
        drain_results();
      if ($urandom_range(0, 1) == 0)
        send_request(FUNC_ALLOC, $urandom());
      else
        send_request(FUNC_RELEASE, pick_release_address());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset registers: base 0, 64-byte blocks,
    // full pool. Two allocations, then a release, a double release, a misaligned
    // release, addresses beyond the pool and at the very top, and one at 0x40.
    send_request(FUNC_ALLOC, 32'hFFFF_FFFF);
    send_request(FUNC_ALLOC, 32'h0000_0000);
    send_request(FUNC_RELEASE, 32'h0000_0000);
    send_request(FUNC_RELEASE, 32'h0000_0000);
    send_request(FUNC_RELEASE, 32'h0000_0041);
    send_request(FUNC_RELEASE, 32'h0001_0000);
    send_request(FUNC_RELEASE, 32'hFFFF_FFFF);
    send_request(FUNC_RELEASE, 32'h0000_0040);

    // A pool of four that straddles the top of the address space: allocated
    // addresses wrap to zero, yet a release of a wrapped address lies outside
    // the pool. The fifth allocation finds the pool empty.
    write_reg(REG_POOL_BASE, 32'hFFFF_FF00);
    write_reg(REG_BLOCK_SIZE, 32'd128);
    write_reg(REG_BLOCK_COUNT, 32'd4);
    repeat (5) send_request(FUNC_ALLOC, $urandom());
    send_request(FUNC_RELEASE, 32'h0000_0000);
    send_request(FUNC_RELEASE, 32'hFFFF_FF80);
    send_request(FUNC_RELEASE, 32'hFFFF_FEFF);

    // A pool with no blocks at all.
    write_reg(REG_BLOCK_COUNT, 32'd0);
    send_request(FUNC_ALLOC, $urandom());
    send_request(FUNC_RELEASE, 32'hFFFF_FF00);

    // Zero-byte blocks: every allocation returns the base, no release fits.
    write_reg(REG_BLOCK_SIZE, 32'd0);
    write_reg(REG_BLOCK_COUNT, 32'd5);
    send_request(FUNC_ALLOC, $urandom());
    send_request(FUNC_ALLOC, $urandom());
    send_request(FUNC_RELEASE, 32'hFFFF_FF00);

    // A count beyond the bound acts as the bound, with the largest block size.
    write_reg(REG_POOL_BASE, 32'h1234_5678);
    write_reg(REG_BLOCK_SIZE, 32'h0000_FFFF);
    write_reg(REG_BLOCK_COUNT, 32'd2047);
    send_request(FUNC_ALLOC, $urandom());
    send_request(FUNC_RELEASE, 32'h1234_5678 + 32'h0000_FFFF * 32'd1023);
    send_request(FUNC_RELEASE, 32'h1234_5678 + 32'h0000_FFFF * 32'd1024);
    send_request(FUNC_RELEASE, 32'h1234_5678);

    // Random part, first with a slow receiver.
    write_reg(REG_POOL_BASE, 32'h0000_1000);
    write_reg(REG_BLOCK_SIZE, 32'd64);
    write_reg(REG_BLOCK_COUNT, 32'd1024);
    run_random(250, 1'b1, 1'b1);
    write_reg(REG_BLOCK_COUNT, 32'd16);
    run_random(200, 1'b0, 1'b0);

    // Then with a slow sender.
    send_idle_pct = 46;
    recv_idle_pct = 24;
    write_reg(REG_POOL_BASE, $urandom());
    write_reg(REG_BLOCK_SIZE, $urandom_range(1, 65535));
    write_reg(REG_BLOCK_COUNT, $urandom_range(1, 1024));
    run_random(200, 1'b1, 1'b0);
    // Base and size change under a partly used pool; the free state stays.
    write_reg(REG_POOL_BASE, 32'hFFFF_FFF0);
    write_reg(REG_BLOCK_SIZE, 32'd1);
    run_random(150, 1'b0, 1'b1);

    // Finally with neither side idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_POOL_BASE, 32'hFFFF_FFFF);
    write_reg(REG_BLOCK_SIZE, 32'h0000_FFFF);
    write_reg(REG_BLOCK_COUNT, 32'd1024);
    run_random(150, 1'b1, 1'b0);
    write_reg(REG_POOL_BASE, 32'd0);
    write_reg(REG_BLOCK_SIZE, 32'd3);
    write_reg(REG_BLOCK_COUNT, 32'd1);
    run_random(100, 1'b0, 1'b0);
    write_reg(REG_BLOCK_SIZE, $urandom_range(1, 256));
    write_reg(REG_BLOCK_COUNT, $urandom_range(1025, 2047));
    run_random(150, 1'b0, 1'b0);
    write_reg(REG_POOL_BASE, $urandom());
    write_reg(REG_BLOCK_SIZE, $urandom_range(1, 16));
    write_reg(REG_BLOCK_COUNT, $urandom_range(1, 40));
    run_random(150, 1'b0, 1'b1);

    // Let the last results come home, then allow a little extra for anything
    // stray before giving the verdict.
    drain_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/fbpa_pkg.sv
rtl/fbpa_div.sv
rtl/fixed_block_pool_allocator_top.sv
tb/fbpa_checker.sv
tb/tb_fixed_block_pool_allocator_top.sv
